// ----- rtl/ptd_pkg.sv -----
package ptd_pkg;

  localparam int unsigned NUMBER_WIDTH = 32;
  // A trial divisor never passes floor(sqrt(2^NUMBER_WIDTH - 1)) + 1
  localparam int unsigned DIV_WIDTH    = NUMBER_WIDTH / 2 + 1;
  localparam int unsigned SQ_WIDTH     = 2 * DIV_WIDTH;
  localparam int unsigned CNT_WIDTH    = $clog2(NUMBER_WIDTH);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);
  localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(4);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BOUND  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_EVAL   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;       // capture a new number, restart at divisor 2
    logic div_start;  // begin a remainder computation
    logic div_step;   // one restoring-division bit
    logic next_div;   // advance divisor and its square
    logic out_load;   // fill the result register
    logic verdict;    // prime flag for the result register
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt_two;
    logic sq_le_n;
    logic div_last;
    logic rem_zero;
  } dp_status_t;

endpackage

// ----- rtl/ptd_datapath.sv -----
module ptd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ptd_pkg::NUMBER_WIDTH-1:0]  number_i,
  input  ptd_pkg::dp_cmd_t                  cmd_i,
  output ptd_pkg::dp_status_t               status_o,
  output logic [ptd_pkg::NUMBER_WIDTH-1:0]  tested_number_o,
  output logic                              is_prime_o
);

  logic [ptd_pkg::NUMBER_WIDTH-1:0] num_q, num_d;
  logic [ptd_pkg::NUMBER_WIDTH-1:0] shift_q, shift_d;
  logic [ptd_pkg::DIV_WIDTH-1:0]    div_q, div_d;
  logic [ptd_pkg::SQ_WIDTH-1:0]     sq_q, sq_d;
  logic [ptd_pkg::DIV_WIDTH-1:0]    rem_q, rem_d;
  logic [ptd_pkg::CNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic [ptd_pkg::NUMBER_WIDTH-1:0] tested_q;
  logic                             prime_q;

  logic [ptd_pkg::DIV_WIDTH:0]      rem_shl;
  logic [ptd_pkg::DIV_WIDTH:0]      rem_sub;
  logic [ptd_pkg::SQ_WIDTH-1:0]     sq_inc;

  // restoring division, one quotient bit per cycle
  assign rem_shl = {rem_q, shift_q[ptd_pkg::NUMBER_WIDTH-1]};
  assign rem_sub = rem_shl - {1'b0, div_q};
  // (d+1)^2 = d^2 + 2d + 1
  assign sq_inc  = sq_q + {(ptd_pkg::SQ_WIDTH-ptd_pkg::DIV_WIDTH-1)'(0), div_q, 1'b1};

  always_comb begin
    num_d   = num_q;
    shift_d = shift_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      num_d = number_i;
      div_d = ptd_pkg::FIRST_DIVISOR;
      sq_d  = ptd_pkg::FIRST_SQUARE;
      rem_d = '0;
    end
    if (cmd_i.div_start) begin
      shift_d = num_q;
      rem_d   = '0;
      cnt_d   = ptd_pkg::CNT_WIDTH'(ptd_pkg::NUMBER_WIDTH - 1);
    end
    if (cmd_i.div_step) begin
      shift_d = {shift_q[ptd_pkg::NUMBER_WIDTH-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      if (rem_shl >= {1'b0, div_q}) begin
        rem_d = rem_sub[ptd_pkg::DIV_WIDTH-1:0];
      end else begin
        rem_d = rem_shl[ptd_pkg::DIV_WIDTH-1:0];
      end
    end
    if (cmd_i.next_div) begin
      div_d = div_q + 1'b1;
      sq_d  = sq_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      shift_q <= '0;
      div_q   <= ptd_pkg::FIRST_DIVISOR;
      sq_q    <= ptd_pkg::FIRST_SQUARE;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      num_q   <= num_d;
      shift_q <= shift_d;
      div_q   <= div_d;
      sq_q    <= sq_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tested_q <= num_q;
      prime_q  <= cmd_i.verdict;
    end
  end

  assign status_o.n_lt_two = (num_q < ptd_pkg::NUMBER_WIDTH'(2));
  assign status_o.sq_le_n  = (sq_q <= {(ptd_pkg::SQ_WIDTH-ptd_pkg::NUMBER_WIDTH)'(0), num_q});
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.rem_zero = (rem_q == '0);

  assign tested_number_o = tested_q;
  assign is_prime_o      = prime_q;

endmodule

// ----- rtl/ptd_ctrl.sv -----
module ptd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ptd_pkg::dp_status_t status_i,
  output ptd_pkg::dp_cmd_t    cmd_o
);

  ptd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            verdict_q, verdict_d;

  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.verdict = verdict_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ptd_pkg::ST_BOUND;
        end
      end
      ptd_pkg::ST_BOUND: begin
        if (status_i.n_lt_two) begin
          verdict_d = 1'b0;
          state_d   = ptd_pkg::ST_FINISH;
        end else if (!status_i.sq_le_n) begin
          verdict_d = 1'b1;
          state_d   = ptd_pkg::ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ptd_pkg::ST_DIVIDE;
        end
      end
      ptd_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ptd_pkg::ST_EVAL;
        end
      end
      ptd_pkg::ST_EVAL: begin
        if (status_i.rem_zero) begin
          verdict_d = 1'b0;
          state_d   = ptd_pkg::ST_FINISH;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ptd_pkg::ST_BOUND;
        end
      end
      ptd_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ptd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      verdict_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
    end
  end

  assign in_stall_o  = (state_q != ptd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/primality_trial_division_top.sv -----
// Trial-division primality tester: one result per input number.
// Numbers 0..3 skip the divider; any other number runs, for each trial divisor,
// a bit-serial remainder over all bits of the number, plus bound check and
// evaluate. The shared serial divider sets the rate.
// Throughput: one number at a time; the next is taken while a result waits.
// Reset: rst_ni asynchronous, active low; returns to idle, no result pending.
module primality_trial_division_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ptd_pkg::NUMBER_WIDTH-1:0] number_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ptd_pkg::NUMBER_WIDTH-1:0] tested_number_o,
  output logic                             is_prime_o
);

  // Controller walks divisors d = 2, 3, ... while d*d <= n. The datapath
  // keeps d*d incrementally, so the bound is one compare with no multiplier.
  ptd_pkg::dp_cmd_t    cmd;
  ptd_pkg::dp_status_t status;

  ptd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: number, divisor, square, remainder, and the result register
  // that lets a new transfer in while the last result is still held.
  ptd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .number_i        (number_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .tested_number_o (tested_number_o),
    .is_prime_o      (is_prime_o)
  );

  // 0 and 1 are never prime
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_prime_o |-> tested_number_o >= ptd_pkg::NUMBER_WIDTH'(2))
    else $error("prime reported below two");

  // 2 and 3 skip the divider and must come out prime
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tested_number_o == ptd_pkg::NUMBER_WIDTH'(2) ||
                    tested_number_o == ptd_pkg::NUMBER_WIDTH'(3)) |-> is_prime_o)
    else $error("two or three not prime");

  // even numbers above two have divisor 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tested_number_o[0] && tested_number_o != ptd_pkg::NUMBER_WIDTH'(2)
    |-> !is_prime_o)
    else $error("even number reported prime");

  // an input transfer always starts a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

endmodule
